FILE: rtl/core/spfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spfp_pkg;

    // fixed field widths
    localparam int unsigned AddrW    = 24;
    localparam int unsigned LenW     = 25;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned UnitW    = 16;
    localparam int unsigned KindW    = 2;
    localparam int unsigned ActW     = 3;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    // depth of the queue between front and back
    localparam int unsigned QueueDepth = 4;

    // register map
    localparam logic [ApbAddrW-1:0] REG_FLASH_SIZE = 3'h0;
    localparam logic [LenW-1:0]     FlashSizeReset = 25'h100_0000;

    // flash command bytes
    localparam logic [ByteW-1:0] CMD_PROGRAM = 8'h02;
    localparam logic [ByteW-1:0] CMD_WREN    = 8'h06;
    localparam logic [ByteW-1:0] CMD_SECTOR  = 8'h20;
    localparam logic [ByteW-1:0] CMD_BLOCK   = 8'hD8;
    localparam logic [ByteW-1:0] CMD_CHIP    = 8'hC7;

    typedef enum logic [KindW-1:0] {
        KIND_PROGRAM = 2'd0,
        KIND_SECTOR  = 2'd1,
        KIND_BLOCK   = 2'd2,
        KIND_CHIP    = 2'd3
    } kind_t;

    typedef enum logic [ActW-1:0] {
        ACT_WAIT   = 3'd0,
        ACT_SEL    = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_DESEL  = 3'd3,
        ACT_REJECT = 3'd4
    } action_t;

    // steps of one job, emitted lowest index first
    localparam int unsigned StepN = 15;
    localparam int unsigned STEP_DESEL_FIRST = 0;
    localparam int unsigned STEP_REJECT      = 1;
    localparam int unsigned STEP_WE_WAIT     = 2;
    localparam int unsigned STEP_WE_SEL      = 3;
    localparam int unsigned STEP_WE_CMD      = 4;
    localparam int unsigned STEP_WE_DESEL    = 5;
    localparam int unsigned STEP_WE_WAIT2    = 6;
    localparam int unsigned STEP_WE_SEL2     = 7;
    localparam int unsigned STEP_CMD         = 8;
    localparam int unsigned STEP_ADDR2       = 9;
    localparam int unsigned STEP_ADDR1       = 10;
    localparam int unsigned STEP_ADDR0       = 11;
    localparam int unsigned STEP_DATA        = 12;
    localparam int unsigned STEP_DESEL_END   = 13;
    localparam int unsigned STEP_WAIT_END    = 14;

    localparam logic [StepN-1:0] WrenSteps = 15'b000_0000_1111_1100;
    localparam logic [StepN-1:0] AddrSteps = 15'b000_1110_0000_0000;

    // one classified item: which steps to run and the bytes they carry
    typedef struct packed {
        logic [StepN-1:0] steps;
        logic [ByteW-1:0] cmd;
        logic [AddrW-1:0] addr;
        logic [ByteW-1:0] data;
    } job_t;

    // action code of each step
    function automatic action_t step_action(input int unsigned idx);
        action_t act;
        act = ACT_WAIT;
        case (idx) inside
            STEP_DESEL_FIRST, STEP_WE_DESEL, STEP_DESEL_END: act = ACT_DESEL;
            STEP_REJECT:                                     act = ACT_REJECT;
            STEP_WE_SEL, STEP_WE_SEL2:                       act = ACT_SEL;
            [STEP_CMD:STEP_DATA], STEP_WE_CMD:               act = ACT_SEND;
            default:                                         act = ACT_WAIT;
        endcase
        return act;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/spfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spfp_front #(
    parameter int unsigned PAGE_BYTES   = 256,
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned BLOCK_BYTES  = 65536,
    parameter int unsigned ADDRESS_BITS = 24
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [spfp_pkg::KindW-1:0]  kind,
    input  wire logic                        first,
    input  wire logic [spfp_pkg::AddrW-1:0]  start_address,
    input  wire logic [spfp_pkg::LenW-1:0]   total_length,
    input  wire logic [spfp_pkg::ByteW-1:0]  data_byte,
    input  wire logic [spfp_pkg::UnitW-1:0]  unit_number,
    input  wire logic [spfp_pkg::LenW-1:0]   flash_size,
    output logic                             push,
    output spfp_pkg::job_t                   job
);
    import spfp_pkg::*;

    // sizes are powers of two
    localparam int unsigned PageLg   = $clog2(PAGE_BYTES);
    localparam int unsigned SectorLg = $clog2(SECTOR_BYTES);
    localparam int unsigned BlockLg  = $clog2(BLOCK_BYTES);
    localparam int unsigned ProdW    = UnitW + 24;
    localparam logic [AddrW-1:0] AddrMask = AddrW'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [AddrW-1:0] next_address_reg, next_address_next;
    logic [LenW-1:0]  bytes_left_reg, bytes_left_next;
    logic             segment_open_reg, segment_open_next;
    logic             dropping_reg, dropping_next;

    logic [AddrW-1:0] start_m;
    logic [AddrW-1:0] addr_inc;
    logic             oversize;
    logic [ProdW-1:0] unit_wide;
    logic [ProdW-1:0] sector_prod;
    logic [ProdW-1:0] block_prod;
    job_t             job_c;

    assign start_m     = start_address & AddrMask;
    assign oversize    = ({2'b00, start_m} + {1'b0, total_length}) > {1'b0, flash_size};
    assign unit_wide   = {{(ProdW-UnitW){1'b0}}, unit_number};
    assign sector_prod = unit_wide << SectorLg;
    assign block_prod  = unit_wide << BlockLg;

    // classify the item and advance the transfer state
    always_comb begin
        next_address_next = next_address_reg;
        bytes_left_next   = bytes_left_reg;
        segment_open_next = segment_open_reg;
        dropping_next     = dropping_reg;
        job_c             = '0;
        addr_inc          = '0;
        if (kind == KIND_PROGRAM) begin
            if (first) begin
                if (bytes_left_reg != '0) begin
                    job_c.steps[STEP_DESEL_FIRST] = segment_open_reg;
                    job_c.steps[STEP_REJECT]      = 1'b1;
                    segment_open_next = 1'b0;
                    bytes_left_next   = '0;
                    dropping_next     = 1'b1;
                end else if (total_length == '0 || oversize) begin
                    job_c.steps[STEP_REJECT] = 1'b1;
                    dropping_next            = 1'b1;
                end else begin
                    dropping_next     = 1'b0;
                    next_address_next = start_m;
                    bytes_left_next   = total_length;
                    segment_open_next = 1'b0;
                end
            end
            if (!dropping_next && bytes_left_next != '0) begin
                if (!segment_open_next) begin
                    job_c.steps       = job_c.steps | WrenSteps | AddrSteps;
                    job_c.steps[STEP_CMD] = 1'b1;
                    job_c.cmd         = CMD_PROGRAM;
                    job_c.addr        = next_address_next;
                    segment_open_next = 1'b1;
                end
                job_c.steps[STEP_DATA] = 1'b1;
                job_c.data             = data_byte;
                addr_inc          = (next_address_next + 24'd1) & AddrMask;
                next_address_next = addr_inc;
                bytes_left_next   = bytes_left_next - 25'd1;
                if (bytes_left_next == '0 || addr_inc[PageLg-1:0] == '0) begin
                    job_c.steps[STEP_DESEL_END] = 1'b1;
                    segment_open_next           = 1'b0;
                    job_c.steps[STEP_WAIT_END]  = (bytes_left_next == '0);
                end
            end
        end else begin
            // erase aborts any open transfer
            job_c.steps[STEP_DESEL_FIRST] = segment_open_reg;
            segment_open_next = 1'b0;
            bytes_left_next   = '0;
            dropping_next     = 1'b0;
            job_c.steps       = job_c.steps | WrenSteps;
            job_c.steps[STEP_CMD]       = 1'b1;
            job_c.steps[STEP_DESEL_END] = 1'b1;
            case (kind)
                KIND_SECTOR: begin
                    job_c.cmd  = CMD_SECTOR;
                    job_c.addr = sector_prod[AddrW-1:0] & AddrMask;
                end
                KIND_BLOCK: begin
                    job_c.cmd  = CMD_BLOCK;
                    job_c.addr = block_prod[AddrW-1:0] & AddrMask;
                end
                default: begin
                    job_c.cmd  = CMD_CHIP;
                    job_c.addr = '0;
                end
            endcase
            if (kind != KIND_CHIP) begin
                job_c.steps = job_c.steps | AddrSteps;
                job_c.steps[STEP_WAIT_END] = 1'b1;
            end
        end
    end

    // only items that cause actions go to the queue
    assign push = accept && (job_c.steps != '0);
    assign job  = job_c;

    // transfer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_address_reg <= '0;
            bytes_left_reg   <= '0;
            segment_open_reg <= 1'b0;
            dropping_reg     <= 1'b0;
        end else if (accept) begin
            next_address_reg <= next_address_next;
            bytes_left_reg   <= bytes_left_next;
            segment_open_reg <= segment_open_next;
            dropping_reg     <= dropping_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module spfp_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire spfp_pkg::job_t  wr_job,
    input  wire logic            pop,
    output spfp_pkg::job_t       rd_job,
    output logic                 empty,
    output logic                 full
);
    import spfp_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    job_t            mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CntW'(QueueDepth));
    assign rd_job = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spfp_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire spfp_pkg::job_t               q_job,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [spfp_pkg::ActW-1:0]         m_action,
    output logic [spfp_pkg::ByteW-1:0]        m_byte,
    output logic                              m_last
);
    import spfp_pkg::*;

    logic [StepN-1:0] steps_reg;
    logic [ByteW-1:0] cmd_reg;
    logic [AddrW-1:0] addr_reg;
    logic [ByteW-1:0] data_reg;

    logic             out_valid_reg;
    logic [ActW-1:0]  out_action_reg;
    logic [ByteW-1:0] out_byte_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             emit;
    logic [StepN-1:0] iso;
    logic [StepN-1:0] rest;
    logic [ActW-1:0]  act_c;
    logic [ByteW-1:0] byte_c;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = out_free && (steps_reg != '0);
    assign iso      = steps_reg & (~steps_reg + 1'b1);
    assign rest     = steps_reg & ~iso;
    assign q_pop    = !q_empty && ((steps_reg == '0) || (emit && rest == '0));

    // decode the current step
    always_comb begin
        act_c = '0;
        for (int unsigned i = 0; i < StepN; i++) begin
            if (iso[i]) begin
                act_c = act_c | step_action(i);
            end
        end
        byte_c = ({ByteW{iso[STEP_WE_CMD]}} & CMD_WREN)
               | ({ByteW{iso[STEP_CMD]}}    & cmd_reg)
               | ({ByteW{iso[STEP_ADDR2]}}  & addr_reg[23:16])
               | ({ByteW{iso[STEP_ADDR1]}}  & addr_reg[15:8])
               | ({ByteW{iso[STEP_ADDR0]}}  & addr_reg[7:0])
               | ({ByteW{iso[STEP_DATA]}}   & data_reg);
    end

    // current job: step mask plus payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (q_pop) begin
            steps_reg <= q_job.steps;
        end else if (emit) begin
            steps_reg <= rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg  <= q_job.cmd;
            addr_reg <= q_job.addr;
            data_reg <= q_job.data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_action_reg <= act_c;
            out_byte_reg   <= byte_c;
            out_last_reg   <= (rest == '0);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_action = out_action_reg;
    assign m_byte   = out_byte_reg;
    assign m_last   = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spi_flash_page_program_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// SPI NOR program/erase sequencer.
// Input stream (s_*): one item per program data byte or per erase request.
// The first byte of a program transfer carries start address and length.
// Output stream (m_*): one item per flash action (wait-ready, select, send
// byte, deselect, reject); m_tlast marks the final action of an input item.
// APB port: register 0 (byte address 0) holds the flash size in use.
// Path: an accepted item is written to the queue, loaded into the back end's
// step register, and its first action is held in the output register.
// Throughput: while m_tready is high, the back end emits one action per cycle.
// A data byte inside an open page costs one action, so such bytes stream at one
// item per cycle; a page start or an erase costs up to 13 actions. A 4-entry
// queue between the classifier and the action sequencer absorbs these bursts,
// so the input keeps flowing while earlier items are still being expanded.
// When m_tready is low the output register holds its action, the sequencer
// stalls, and s_tready drops once the queue is full.
// Reset clears transfer state, queue and output; flash size returns to 16 MiB.
module spi_flash_page_program_sequencer #(
    parameter int unsigned PAGE_BYTES   = 256,
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned BLOCK_BYTES  = 65536,
    parameter int unsigned ADDRESS_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_address[23:0], total_length[48:24], data_byte[56:49], unit_number[72:57]
    input  wire logic [79:0]                     s_tdata,
    // kind[1:0], first[2]
    input  wire logic [2:0]                      s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // action[2:0], spi_byte[10:3]
    output logic [15:0]                          m_tdata,
    output logic                                 m_tlast,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spfp_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [spfp_pkg::ApbDataW-1:0]   pwdata,
    output logic [spfp_pkg::ApbDataW-1:0]        prdata,
    output logic                                 pready
);
    import spfp_pkg::*;

    logic [LenW-1:0]  flash_size_reg;
    logic             cfg_wr;
    logic             reg_hit;

    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    job_t             front_job;
    job_t             q_job;

    logic             s_accept;
    logic [ActW-1:0]  out_action;
    logic [ByteW-1:0] out_byte;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[ApbAddrW-1:2] == REG_FLASH_SIZE[ApbAddrW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {{(ApbDataW-LenW){1'b0}}, flash_size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_size_reg <= FlashSizeReset;
        end else if (cfg_wr) begin
            flash_size_reg <= pwdata[LenW-1:0];
        end
    end

    // front: classify items
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    spfp_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .kind          (s_tuser[1:0]),
        .first         (s_tuser[2]),
        .start_address (s_tdata[23:0]),
        .total_length  (s_tdata[48:24]),
        .data_byte     (s_tdata[56:49]),
        .unit_number   (s_tdata[72:57]),
        .flash_size    (flash_size_reg),
        .push          (q_push),
        .job           (front_job)
    );

    // job queue
    spfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (front_job),
        .pop     (q_pop),
        .rd_job  (q_job),
        .empty   (q_empty),
        .full    (q_full)
    );

    // back: expand jobs into actions
    spfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (q_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_action (out_action),
        .m_byte   (out_byte),
        .m_last   (m_tlast)
    );

    assign m_tdata = {5'b00000, out_byte, out_action};

    // checks
    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job queue written while full");

    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("job queue read while empty");

    a_byte_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != ACT_SEND) |-> (m_tdata[10:3] == 8'h00))
        else $error("spi byte set on a non-send action");

endmodule

`default_nettype wire
